[hw/rtl/rgb_to_ycbcr420_planar_core_assert.svh]
// assertion macros for the ycbcr 4:2:0 converter
// both macros use the enclosing module's clk and rst_n
`ifndef RGB_TO_YCBCR420_PLANAR_CORE_ASSERT_SVH
`define RGB_TO_YCBCR420_PLANAR_CORE_ASSERT_SVH

// same-cycle implication
`define YCC_ASSERT_IMPLIES(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ycc420 assertion failed");

// next-cycle implication
`define YCC_ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ycc420 assertion failed");

`endif

[hw/rtl/ycc420_pkg.sv]
package ycc420_pkg;

    localparam int CFG_W          = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int PIX_W          = 8;
    localparam int LUMA_INDEX_W   = 24;
    localparam int CHROMA_INDEX_W = 22;
    localparam int COORD_W        = 13;
    localparam int LUMA_SUM_W     = 24;
    localparam int DIFF_W         = 9;
    localparam int CPROD_W        = 26;
    localparam int CHROMA_Q_W     = 11;
    localparam int QUEUE_DEPTH    = 2;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH   = 13'd1920;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT  = 13'd1080;
    localparam logic [CFG_W-1:0] RESET_ACTIVE_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RESET_ACTIVE_HEIGHT = 13'd1080;

    localparam logic [15:0] Y_R_COEF = 16'd19595;
    localparam logic [15:0] Y_G_COEF = 16'd38470;
    localparam logic [15:0] Y_B_COEF = 16'd7471;

    localparam logic signed [16:0] CB_COEF = 17'sd36962;
    localparam logic signed [16:0] CR_COEF = 17'sd46727;

    localparam logic signed [CHROMA_Q_W-1:0] CHROMA_OFFSET = 11'sd128;
    localparam logic signed [CHROMA_Q_W-1:0] CHROMA_MAX    = 11'sd255;
    localparam logic signed [CHROMA_Q_W-1:0] CHROMA_MIN    = 11'sd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_ACTIVE_WIDTH  = 2'd2,
        CFG_ACTIVE_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               chroma_valid;
        logic               frame_end;
    } entry_t;

    // floor shift by 16, add offset, clamp to 0..255
    function automatic logic [PIX_W-1:0] chroma_clamp(input logic signed [CPROD_W-1:0] p);
        logic signed [CHROMA_Q_W-1:0] q;
        logic [PIX_W-1:0]             r;
        q = CHROMA_Q_W'(p >>> 16) + CHROMA_OFFSET;
        if (q < CHROMA_MIN) begin
            r = '0;
        end else if (q > CHROMA_MAX) begin
            r = '1;
        end else begin
            r = q[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/ycc420_if.sv]
interface ycc420_pixel_if;
    import ycc420_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ycc420_result_if;
    import ycc420_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PIX_W-1:0]          luma;
    logic [LUMA_INDEX_W-1:0]   luma_index;
    logic                      chroma_valid;
    logic [PIX_W-1:0]          blue_diff;
    logic [PIX_W-1:0]          red_diff;
    logic [CHROMA_INDEX_W-1:0] chroma_index;
    logic                      frame_end;

    modport source (
        output valid, output luma, output luma_index, output chroma_valid,
        output blue_diff, output red_diff, output chroma_index, output frame_end,
        input ready
    );
    modport sink (
        input valid, input luma, input luma_index, input chroma_valid,
        input blue_diff, input red_diff, input chroma_index, input frame_end,
        output ready
    );
endinterface

[hw/rtl/rgb_to_ycbcr420_planar_core.sv]
// RGB to Y'CbCr 4:2:0 planar converter. Takes one RGB pixel per transfer in raster
// order and returns one result per pixel: luma with its row-flipped luma plane index,
// and on even row and column also Cb, Cr and the row-flipped chroma plane index.
// Pixels outside the active area are converted as black. Sustained rate is one pixel
// per clock while the output is not stalled; a result passes through the two-entry
// queue, written at the transfer edge itself, and then the four register stages of
// the back end (three multiply stages and the output register); the queue becomes
// full only while the output is stalled. The user must write configuration only
// while no pixel is in flight; the block itself does not enforce this.
module rgb_to_ycbcr420_planar_core #(
    parameter int MAX_WIDTH   = ycc420_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ycc420_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [ycc420_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ycc420_pkg::CFG_W-1:0]       cfg_data,
    ycc420_pixel_if.sink                       pixel,
    ycc420_result_if.source                    result
);
    import ycc420_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int DWW = (CFG_W > WW) ? CFG_W : WW;
    localparam int DHW = (CFG_W > HW) ? CFG_W : HW;

    logic [CFG_W-1:0] frame_w_reg, frame_h_reg, active_w_reg, active_h_reg;
    logic [DWW-1:0]   w_clamp;
    logic [DHW-1:0]   h_clamp;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;

    logic   queue_push;
    logic   queue_full;
    logic   queue_valid;
    logic   queue_pop;
    entry_t front_entry;
    entry_t queue_entry;

    logic   chroma_fields_zero;
    logic   end_index_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg  <= RESET_FRAME_WIDTH;
            frame_h_reg  <= RESET_FRAME_HEIGHT;
            active_w_reg <= RESET_ACTIVE_WIDTH;
            active_h_reg <= RESET_ACTIVE_HEIGHT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:   frame_w_reg  <= cfg_data;
                CFG_FRAME_HEIGHT:  frame_h_reg  <= cfg_data;
                CFG_ACTIVE_WIDTH:  active_w_reg <= cfg_data;
                CFG_ACTIVE_HEIGHT: active_h_reg <= cfg_data;
                default:           frame_w_reg  <= frame_w_reg;
            endcase
        end
    end

    // frame size clamped to 2..max and rounded down to even
    always_comb
    begin
        w_clamp = DWW'(frame_w_reg);
        if (w_clamp < DWW'(2))
        begin
            w_clamp = DWW'(2);
        end
        if (w_clamp > DWW'(MAX_WIDTH))
        begin
            w_clamp = DWW'(MAX_WIDTH);
        end
        h_clamp = DHW'(frame_h_reg);
        if (h_clamp < DHW'(2))
        begin
            h_clamp = DHW'(2);
        end
        if (h_clamp > DHW'(MAX_HEIGHT))
        begin
            h_clamp = DHW'(MAX_HEIGHT);
        end
        eff_w = WW'(w_clamp) & ~WW'(1);
        eff_h = HW'(h_clamp) & ~HW'(1);
    end

    ycc420_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .active_w   (active_w_reg),
        .active_h   (active_h_reg),
        .pixel      (pixel),
        .queue_full (queue_full),
        .push       (queue_push),
        .entry      (front_entry)
    );

    ycc420_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .entry_in  (front_entry),
        .full      (queue_full),
        .valid     (queue_valid),
        .pop       (queue_pop),
        .entry_out (queue_entry)
    );

    ycc420_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .queue_valid (queue_valid),
        .entry       (queue_entry),
        .pop         (queue_pop),
        .result      (result)
    );

    assign chroma_fields_zero = (result.blue_diff == '0) && (result.red_diff == '0) &&
                                (result.chroma_index == '0);
    assign end_index_ok       = (result.luma_index == LUMA_INDEX_W'(eff_w - WW'(1))) &&
                                !result.chroma_valid;

`include "rgb_to_ycbcr420_planar_core_assert.svh"

    // no chroma payload on odd rows or columns
`YCC_ASSERT_IMPLIES(a_chroma_zero, result.valid && !result.chroma_valid, chroma_fields_zero)
    // last pixel sits in the first flipped row, last column, odd position
`YCC_ASSERT_IMPLIES(a_end_index, result.valid && result.frame_end, end_index_ok)
    // a queued entry is offered to the back end on the next cycle
`YCC_ASSERT_NEXT(a_queue_push_seen, queue_push, queue_valid)

endmodule

[hw/rtl/ycc420_front.sv]
module ycc420_front #(
    parameter int MAX_WIDTH   = ycc420_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ycc420_pkg::DEFAULT_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [WW-1:0]                eff_w,
    input  logic [HW-1:0]                eff_h,
    input  logic [ycc420_pkg::CFG_W-1:0] active_w,
    input  logic [ycc420_pkg::CFG_W-1:0] active_h,
    ycc420_pixel_if.sink                 pixel,
    input  logic                         queue_full,
    output logic                         push,
    output ycc420_pkg::entry_t           entry
);
    import ycc420_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0] row_reg, row_next, row_cur;
    logic          col_at_end;
    logic          row_at_end;
    logic          active;

    // counters left beyond a shrunken frame restart at zero
    always_comb
    begin
        col_cur    = (WW'(col_reg) >= eff_w) ? '0 : col_reg;
        row_cur    = (HW'(row_reg) >= eff_h) ? '0 : row_reg;
        col_at_end = (WW'(col_cur) == (eff_w - WW'(1)));
        row_at_end = (HW'(row_cur) == (eff_h - HW'(1)));
        active     = (CFG_W'(row_cur) < active_h) && (CFG_W'(col_cur) < active_w);
    end

    assign pixel.ready = !queue_full;
    assign push        = pixel.valid && !queue_full;

    always_comb
    begin
        entry.red          = active ? pixel.red   : '0;
        entry.green        = active ? pixel.green : '0;
        entry.blue         = active ? pixel.blue  : '0;
        entry.row          = COORD_W'(row_cur);
        entry.col          = COORD_W'(col_cur);
        entry.chroma_valid = !row_cur[0] && !col_cur[0];
        entry.frame_end    = row_at_end && col_at_end;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (col_at_end)
            begin
                col_next = '0;
                row_next = row_at_end ? '0 : row_cur + RW'(1);
            end
            else
            begin
                col_next = col_cur + CW'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[hw/rtl/ycc420_queue.sv]
module ycc420_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ycc420_pkg::entry_t entry_in,
    output logic               full,
    output logic               valid,
    input  logic               pop,
    output ycc420_pkg::entry_t entry_out
);
    import ycc420_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    entry_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign entry_out = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/ycc420_back.sv]
module ycc420_back #(
    parameter int MAX_WIDTH   = ycc420_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ycc420_pkg::DEFAULT_MAX_HEIGHT,
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WW-1:0]      eff_w,
    input  logic [HW-1:0]      eff_h,
    input  logic               queue_valid,
    input  ycc420_pkg::entry_t entry,
    output logic               pop,
    ycc420_result_if.source    result
);
    import ycc420_pkg::*;

    localparam int PRW = HW + WW;
    localparam int LIW = (PRW + 1 > LUMA_INDEX_W) ? PRW + 1 : LUMA_INDEX_W;
    localparam int CIW = (PRW + 1 > CHROMA_INDEX_W) ? PRW + 1 : CHROMA_INDEX_W;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: luma products, flipped rows
    logic [LUMA_SUM_W-1:0] s1_pr_reg, s1_pg_reg, s1_pb_reg;
    logic [HW-1:0]         s1_rflip_reg, s1_cflip_reg;
    logic [WW-1:0]         s1_col_reg;
    logic [PIX_W-1:0]      s1_red_reg, s1_blue_reg;
    logic                  s1_cv_reg, s1_end_reg;

    // stage 2: luma, index products
    logic [PIX_W-1:0]      s2_luma_reg, s2_red_reg, s2_blue_reg;
    logic [PRW-1:0]        s2_lprod_reg, s2_cprod_reg;
    logic [WW-1:0]         s2_col_reg;
    logic                  s2_cv_reg, s2_end_reg;
    logic [LUMA_SUM_W-1:0] s2_sum;

    // stage 3: indices, chroma products
    logic [PIX_W-1:0]          s3_luma_reg;
    logic [LUMA_INDEX_W-1:0]   s3_lidx_reg;
    logic [CHROMA_INDEX_W-1:0] s3_cidx_reg;
    logic signed [CPROD_W-1:0] s3_cb_reg, s3_cr_reg;
    logic                      s3_cv_reg, s3_end_reg;
    logic signed [DIFF_W-1:0]  s3_db, s3_dr;
    logic [LIW-1:0]            s3_lsum;
    logic [CIW-1:0]            s3_csum;

    // stage 4: output register
    logic [PIX_W-1:0]          o_luma_reg, o_cb_reg, o_cr_reg;
    logic [LUMA_INDEX_W-1:0]   o_lidx_reg;
    logic [CHROMA_INDEX_W-1:0] o_cidx_reg;
    logic                      o_cv_reg, o_end_reg;

    assign en4 = !v4_reg || result.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = queue_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= queue_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pr_reg    <= LUMA_SUM_W'(Y_R_COEF) * LUMA_SUM_W'(entry.red);
            s1_pg_reg    <= LUMA_SUM_W'(Y_G_COEF) * LUMA_SUM_W'(entry.green);
            s1_pb_reg    <= LUMA_SUM_W'(Y_B_COEF) * LUMA_SUM_W'(entry.blue);
            s1_rflip_reg <= eff_h - HW'(1) - HW'(entry.row);
            s1_cflip_reg <= (eff_h >> 1) - HW'(1) - HW'(entry.row >> 1);
            s1_col_reg   <= WW'(entry.col);
            s1_red_reg   <= entry.red;
            s1_blue_reg  <= entry.blue;
            s1_cv_reg    <= entry.chroma_valid;
            s1_end_reg   <= entry.frame_end;
        end
    end

    assign s2_sum = s1_pr_reg + s1_pg_reg + s1_pb_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_luma_reg  <= s2_sum[LUMA_SUM_W-1 -: PIX_W];
            s2_lprod_reg <= PRW'(s1_rflip_reg) * PRW'(eff_w);
            s2_cprod_reg <= PRW'(s1_cflip_reg) * PRW'(eff_w >> 1);
            s2_col_reg   <= s1_col_reg;
            s2_red_reg   <= s1_red_reg;
            s2_blue_reg  <= s1_blue_reg;
            s2_cv_reg    <= s1_cv_reg;
            s2_end_reg   <= s1_end_reg;
        end
    end

    always_comb
    begin
        s3_db   = $signed({1'b0, s2_blue_reg}) - $signed({1'b0, s2_luma_reg});
        s3_dr   = $signed({1'b0, s2_red_reg}) - $signed({1'b0, s2_luma_reg});
        s3_lsum = LIW'(s2_lprod_reg) + LIW'(s2_col_reg);
        s3_csum = CIW'(s2_cprod_reg) + CIW'(s2_col_reg >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_luma_reg <= s2_luma_reg;
            s3_lidx_reg <= s3_lsum[LUMA_INDEX_W-1:0];
            s3_cidx_reg <= s3_csum[CHROMA_INDEX_W-1:0];
            s3_cb_reg   <= CPROD_W'(s3_db) * CPROD_W'(CB_COEF);
            s3_cr_reg   <= CPROD_W'(s3_dr) * CPROD_W'(CR_COEF);
            s3_cv_reg   <= s2_cv_reg;
            s3_end_reg  <= s2_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            o_luma_reg <= s3_luma_reg;
            o_lidx_reg <= s3_lidx_reg;
            o_cb_reg   <= s3_cv_reg ? chroma_clamp(s3_cb_reg) : '0;
            o_cr_reg   <= s3_cv_reg ? chroma_clamp(s3_cr_reg) : '0;
            o_cidx_reg <= s3_cv_reg ? s3_cidx_reg : '0;
            o_cv_reg   <= s3_cv_reg;
            o_end_reg  <= s3_end_reg;
        end
    end

    assign result.valid        = v4_reg;
    assign result.luma         = o_luma_reg;
    assign result.luma_index   = o_lidx_reg;
    assign result.chroma_valid = o_cv_reg;
    assign result.blue_diff    = o_cb_reg;
    assign result.red_diff     = o_cr_reg;
    assign result.chroma_index = o_cidx_reg;
    assign result.frame_end    = o_end_reg;

endmodule
